>>> rtl/core/tns_pkg.sv
`timescale 1ns / 1ps

package tns_pkg;

    localparam int FREQ_W    = 16;
    localparam int BEATS_W   = 12;
    localparam int TEMPO_W   = 10;
    localparam int OPCODE_W  = 2;
    localparam int FRAC_BITS = 8;
    localparam int MUL_STEPS = 16;

    localparam logic [FREQ_W-1:0]  MS_PER_MIN  = 16'd60000;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 10'd120;

    localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_STATUS = 2'd3;

    // serial unit command / status
    typedef struct packed {
        logic start;
        logic div;
    } tns_op_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } tns_sts_t;

    typedef struct packed {
        logic [FREQ_W-1:0] tone_freq;
        logic              sounding;
        logic              busy_res;
        logic              note_done;
        logic              rejected;
    } tns_res_t;

endpackage

>>> rtl/core/tns_channels.sv
`timescale 1ns / 1ps

interface tns_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [tns_pkg::OPCODE_W-1:0]  opcode;
    logic [tns_pkg::FREQ_W-1:0]    start_freq;
    logic [tns_pkg::FREQ_W-1:0]    end_freq;
    logic [tns_pkg::BEATS_W-1:0]   beats_fixed;
    logic                          tied;

    modport source (output valid, opcode, start_freq, end_freq, beats_fixed, tied,
                    input ready);
    modport sink   (input valid, opcode, start_freq, end_freq, beats_fixed, tied,
                    output ready);
endinterface

interface tns_res_if;
    logic                        valid;
    logic                        ready;
    logic [tns_pkg::FREQ_W-1:0]  tone_freq;
    logic                        sounding;
    logic                        busy_res;
    logic                        note_done;
    logic                        rejected;

    modport source (output valid, tone_freq, sounding, busy_res, note_done, rejected,
                    input ready);
    modport sink   (input valid, tone_freq, sounding, busy_res, note_done, rejected,
                    output ready);
endinterface

interface tns_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tns_pkg::TEMPO_W-1:0]  tempo_bpm;

    modport source (output valid, tempo_bpm, input ready);
    modport sink   (input valid, tempo_bpm, output ready);
endinterface

>>> rtl/core/tns_serial_unit.sv
`timescale 1ns / 1ps

module tns_serial_unit #(
    parameter int W  = 36,
    parameter int DW = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tns_pkg::tns_op_t    op,
    input  logic [W-1:0]        opa,
    input  logic [W-1:0]        opb,
    output logic [W-1:0]        result,
    output tns_pkg::tns_sts_t   sts
);
    import tns_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 div_reg, div_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         opnd_reg, opnd_next;
    logic [MUL_STEPS-1:0] mplr_reg, mplr_next;
    logic [DW-1:0]        rem_reg, rem_next;

    logic [DW:0]          rem_shift;
    logic [DW:0]          rem_diff;
    logic                 qbit;

    assign rem_shift = {rem_reg, acc_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, opnd_reg[DW-1:0]};
    assign qbit      = (rem_shift >= {1'b0, opnd_reg[DW-1:0]});

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        acc_next  = acc_reg;
        opnd_next = opnd_reg;
        mplr_next = mplr_reg;
        rem_next  = rem_reg;
        if (op.start)
        begin
            busy_next = 1'b1;
            div_next  = op.div;
            acc_next  = op.div ? opa : '0;
            opnd_next = op.div ? opb : opa;
            mplr_next = opb[MUL_STEPS-1:0];
            rem_next  = '0;
            cnt_next  = op.div ? CW'(W) : CW'(MUL_STEPS);
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // restoring divide, one quotient bit a cycle
                if (qbit)
                    rem_next = rem_diff[DW-1:0];
                else
                    rem_next = rem_shift[DW-1:0];
                acc_next = {acc_reg[W-2:0], qbit};
            end
            else
            begin
                // shift-add multiply
                if (mplr_reg[0])
                    acc_next = acc_reg + opnd_reg;
                opnd_next = {opnd_reg[W-2:0], 1'b0};
                mplr_next = {1'b0, mplr_reg[MUL_STEPS-1:1]};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            div_reg  <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        opnd_reg <= opnd_next;
        mplr_reg <= mplr_next;
        rem_reg  <= rem_next;
    end

    assign result     = acc_reg;
    assign sts.done   = done_reg;
    assign sts.rem_nz = |rem_reg;

endmodule

>>> rtl/core/tone_note_sequencer_glide.sv
`timescale 1ns / 1ps

// Tone sequencer with linear glide. Each command beat is one 1 ms tick, a note load,
// a stop, or a status poll, and yields exactly one result beat. Loads and gliding
// ticks run on one shared bit-serial multiply/divide unit: a load takes a
// (DURATION_BITS+16)-bit divide for 60000/tempo plus a 16-step multiply by beats,
// a gliding tick a 16-step multiply plus a (DURATION_BITS+16)-step divide; every
// other beat goes from S_EXEC straight to S_EMIT. The block takes one command at
// a time; a result may wait in the output register while the next command is taken.
// tempo_bpm must be written only while idle; the block itself does not enforce this.

module tone_note_sequencer_glide #(
    parameter int GAP_TICKS     = 20,
    parameter int DURATION_BITS = 20
) (
    input  logic      clk,
    input  logic      rst_n,
    tns_cmd_if.sink   cmd,
    tns_res_if.source res,
    tns_cfg_if.sink   cfg
);
    import tns_pkg::*;

    localparam int DW = DURATION_BITS;
    localparam int W  = DW + FREQ_W;

    localparam logic [DW-1:0] GAP_CMP = DW'(GAP_TICKS);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NOTE = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    localparam logic [2:0] S_WAIT      = 3'd0;
    localparam logic [2:0] S_EXEC      = 3'd1;
    localparam logic [2:0] S_DIV_TEMPO = 3'd2;
    localparam logic [2:0] S_MUL_BEATS = 3'd3;
    localparam logic [2:0] S_MUL_GLIDE = 3'd4;
    localparam logic [2:0] S_DIV_GLIDE = 3'd5;
    localparam logic [2:0] S_EMIT      = 3'd6;

    logic [2:0]          seq_reg, seq_next;
    logic [1:0]          phase_reg, phase_next;
    logic [DW-1:0]       elapsed_reg, elapsed_next;
    logic [DW-1:0]       note_reg, note_next;
    logic [FREQ_W-1:0]   gstart_reg, gstart_next;
    logic [FREQ_W-1:0]   gend_reg, gend_next;
    logic                tie_reg, tie_next;
    logic [FREQ_W-1:0]   hfreq_reg, hfreq_next;
    logic                hsnd_reg, hsnd_next;
    logic [TEMPO_W-1:0]  tempo_reg;
    tns_res_t            pend_reg, pend_next;
    tns_res_t            out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [OPCODE_W-1:0] op_reg;
    logic [FREQ_W-1:0]   sf_reg;
    logic [FREQ_W-1:0]   ef_reg;
    logic [BEATS_W-1:0]  beats_reg;
    logic                tied_reg;

    tns_op_t             u_op;
    logic [W-1:0]        u_a, u_b;
    logic [W-1:0]        u_result;
    tns_sts_t            u_sts;

    logic [TEMPO_W-1:0]  tempo_eff;
    logic                rising;
    logic [FREQ_W-1:0]   absdiff;
    logic [FREQ_W-1:0]   glide_q;
    logic [FREQ_W-1:0]   glide_f;
    logic [DW-1:0]       dur_sat;

    function automatic tns_res_t mk_res(input logic [FREQ_W-1:0] f, input logic s,
                                        input logic busy, input logic done,
                                        input logic rej);
        tns_res_t r;
        r.tone_freq = s ? f : '0;
        r.sounding  = s;
        r.busy_res  = busy;
        r.note_done = done;
        r.rejected  = rej;
        return r;
    endfunction

    tns_serial_unit #(
        .W  (W),
        .DW (DW)
    ) u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (u_op),
        .opa    (u_a),
        .opb    (u_b),
        .result (u_result),
        .sts    (u_sts)
    );

    assign tempo_eff = (tempo_reg == '0) ? TEMPO_W'(1) : tempo_reg;
    assign rising    = (gend_reg >= gstart_reg);
    assign absdiff   = rising ? (gend_reg - gstart_reg) : (gstart_reg - gend_reg);
    assign glide_q   = u_result[FREQ_W-1:0];
    assign glide_f   = rising ? (gstart_reg + glide_q)
                              : (gstart_reg - glide_q - FREQ_W'(u_sts.rem_nz));
    assign dur_sat   = (|u_result[W-1:DW+FRAC_BITS]) ? '1
                                                     : u_result[DW+FRAC_BITS-1:FRAC_BITS];

    always_comb
    begin
        seq_next       = seq_reg;
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        note_next      = note_reg;
        gstart_next    = gstart_reg;
        gend_next      = gend_reg;
        tie_next       = tie_reg;
        hfreq_next     = hfreq_reg;
        hsnd_next      = hsnd_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        u_op           = '0;
        u_a            = '0;
        u_b            = '0;

        if (out_valid_reg && res.ready)
            out_valid_next = 1'b0;

        unique case (seq_reg)
            S_WAIT:
            begin
                if (cmd.valid)
                    seq_next = S_EXEC;
            end
            S_EXEC:
            begin
                seq_next = S_EMIT;
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        if (phase_reg != PH_IDLE)
                        begin
                            pend_next = mk_res(hfreq_reg, hsnd_reg, 1'b1, 1'b0, 1'b1);
                        end
                        else
                        begin
                            gstart_next  = sf_reg;
                            gend_next    = ef_reg;
                            tie_next     = tied_reg;
                            elapsed_next = '0;
                            hfreq_next   = '0;
                            hsnd_next    = 1'b0;
                            phase_next   = PH_NOTE;
                            pend_next    = mk_res('0, 1'b0, 1'b1, 1'b0, 1'b0);
                            u_op.start   = 1'b1;
                            u_op.div     = 1'b1;
                            u_a          = W'(MS_PER_MIN);
                            u_b          = W'(tempo_eff);
                            seq_next     = S_DIV_TEMPO;
                        end
                    end
                    OP_STOP:
                    begin
                        phase_next   = PH_IDLE;
                        elapsed_next = '0;
                        hfreq_next   = '0;
                        hsnd_next    = 1'b0;
                        pend_next    = mk_res('0, 1'b0, 1'b0, 1'b0, 1'b0);
                    end
                    OP_STATUS:
                    begin
                        if (phase_reg != PH_IDLE)
                            pend_next = mk_res(hfreq_reg, hsnd_reg, 1'b1, 1'b0, 1'b0);
                        else
                            pend_next = mk_res('0, 1'b0, 1'b0, 1'b0, 1'b0);
                    end
                    default:
                    begin
                        // tick
                        priority if (phase_reg == PH_NOTE && elapsed_reg < note_reg)
                        begin
                            if (gstart_reg != '0)
                            begin
                                u_op.start = 1'b1;
                                u_op.div   = 1'b0;
                                u_a        = W'(elapsed_reg);
                                u_b        = W'(absdiff);
                                seq_next   = S_MUL_GLIDE;
                            end
                            else
                            begin
                                hfreq_next   = '0;
                                hsnd_next    = 1'b0;
                                elapsed_next = elapsed_reg + DW'(1);
                                pend_next    = mk_res('0, 1'b0, 1'b1, 1'b0, 1'b0);
                            end
                        end
                        else if (phase_reg == PH_NOTE && !tie_reg && GAP_CMP != '0)
                        begin
                            phase_next   = PH_GAP;
                            elapsed_next = DW'(1);
                            pend_next    = mk_res(hfreq_reg, hsnd_reg, 1'b1, 1'b0, 1'b0);
                        end
                        else if (phase_reg == PH_GAP && elapsed_reg < GAP_CMP)
                        begin
                            elapsed_next = elapsed_reg + DW'(1);
                            pend_next    = mk_res(hfreq_reg, hsnd_reg, 1'b1, 1'b0, 1'b0);
                        end
                        else if (phase_reg == PH_IDLE)
                        begin
                            pend_next = mk_res('0, 1'b0, 1'b0, 1'b0, 1'b0);
                        end
                        else
                        begin
                            // note and gap over
                            phase_next   = PH_IDLE;
                            elapsed_next = '0;
                            pend_next    = mk_res('0, 1'b0, 1'b0, 1'b1, 1'b0);
                        end
                    end
                endcase
            end
            S_DIV_TEMPO:
            begin
                if (u_sts.done)
                begin
                    u_op.start = 1'b1;
                    u_op.div   = 1'b0;
                    u_a        = W'(u_result[FREQ_W-1:0]);
                    u_b        = W'(beats_reg);
                    seq_next   = S_MUL_BEATS;
                end
            end
            S_MUL_BEATS:
            begin
                if (u_sts.done)
                begin
                    note_next = dur_sat;
                    seq_next  = S_EMIT;
                end
            end
            S_MUL_GLIDE:
            begin
                if (u_sts.done)
                begin
                    u_op.start = 1'b1;
                    u_op.div   = 1'b1;
                    u_a        = u_result;
                    u_b        = W'(note_reg);
                    seq_next   = S_DIV_GLIDE;
                end
            end
            S_DIV_GLIDE:
            begin
                if (u_sts.done)
                begin
                    hfreq_next   = glide_f;
                    hsnd_next    = 1'b1;
                    elapsed_next = elapsed_reg + DW'(1);
                    pend_next    = mk_res(glide_f, 1'b1, 1'b1, 1'b0, 1'b0);
                    seq_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    seq_next       = S_WAIT;
                end
            end
            default:
            begin
                seq_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= S_WAIT;
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            note_reg      <= '0;
            gstart_reg    <= '0;
            gend_reg      <= '0;
            tie_reg       <= 1'b0;
            hfreq_reg     <= '0;
            hsnd_reg      <= 1'b0;
            tempo_reg     <= TEMPO_RESET;
            pend_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            note_reg      <= note_next;
            gstart_reg    <= gstart_next;
            gend_reg      <= gend_next;
            tie_reg       <= tie_next;
            hfreq_reg     <= hfreq_next;
            hsnd_reg      <= hsnd_next;
            pend_reg      <= pend_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                tempo_reg <= cfg.tempo_bpm;
        end
    end

    // command beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg    <= cmd.opcode;
            sf_reg    <= cmd.start_freq;
            ef_reg    <= cmd.end_freq;
            beats_reg <= cmd.beats_fixed;
            tied_reg  <= cmd.tied;
        end
    end

    assign cmd.ready     = (seq_reg == S_WAIT);
    assign cfg.ready     = 1'b1;
    assign res.valid     = out_valid_reg;
    assign res.tone_freq = out_reg.tone_freq;
    assign res.sounding  = out_reg.sounding;
    assign res.busy_res  = out_reg.busy_res;
    assign res.note_done = out_reg.note_done;
    assign res.rejected  = out_reg.rejected;

endmodule
